>>> rtl/b32c_pkg.sv
// Shared types, constants and symbol tables for the Base32 stream codec.
// Depends on nothing; used by the controller, the datapath and the top level.
package b32c_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [7:0] ALPHABET [32] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
        8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52,
        8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
        8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
    };

    typedef struct packed {
        logic accept;   // latch a new input word
        logic emit;     // load one result into the output register
    } cmd_t;

    typedef struct packed {
        logic res_avail;  // a result is ready to leave for the current word
        logic res_final;  // the pending result finishes the current word
        logic out_free;   // the output register can take a result this cycle
    } stat_t;

    function automatic logic [7:0] sym_char(input logic [4:0] idx);
        sym_char = ALPHABET[idx];
    endfunction

    // Bit 5 set means the character is not in the alphabet.
    function automatic logic [5:0] char_index(input logic [7:0] c);
        logic [7:0] up;
        logic [5:0] idx;
        up = c;
        idx = 6'h20;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            up = c - 8'h20;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (ALPHABET[i] == up)
            begin
                idx = 6'(i);
            end
        end
        char_index = idx;
    endfunction

endpackage

>>> rtl/base32_stream_codec_core.sv
// Top level of the Base32 stream codec: joins the controller and datapath.
// Depends on b32c_pkg, b32c_ctrl and b32c_datapath.
//
//  channel   handshake            payload
//  s_*       s_tvalid / s_tready  s_tdata = byte_in, s_tlast = end_of_message
//  m_*       m_tvalid / m_tready  m_tdata = value_out, m_tuser = valid_res,
//                                 m_tlast = last
//  cfg_*     cfg_we               cfg_wdata = direction (0 encode, 1 decode)
//
// A word is taken while the controller is idle, then its results leave one per
// cycle from the output register while m_tready does not stall. Decoding gives
// one result per word. Encoding gives one result per symbol; at message end
// flush and padding add up to seven symbols.
// A stalled m_tready holds the controller in its drain state.
// Reset clears the direction to encode and all message state.
module base32_stream_codec_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] value_out
    output logic       m_tuser,   // [0] valid_res
    output logic       m_tlast,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);

    b32c_pkg::cmd_t  cmd;
    b32c_pkg::stat_t stat;

    b32c_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    b32c_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_tdata),
        .in_eom    (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_value (m_tdata),
        .out_flag  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

>>> rtl/b32c_ctrl.sv
// Controller for the Base32 stream codec: takes one input word, then drains
// its results one per cycle while stat.out_free is set. Depends on b32c_pkg.
module b32c_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  b32c_pkg::stat_t stat,
    output b32c_pkg::cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (!stat.res_avail)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.res_final)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/b32c_datapath.sv
// Datapath for the Base32 stream codec: bit accumulator, symbol counter,
// direction register and the output register. Depends on b32c_pkg.
module b32c_datapath
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    input  logic [7:0]      in_byte,
    input  logic            in_eom,
    input  b32c_pkg::cmd_t  cmd,
    output b32c_pkg::stat_t stat,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [7:0]      out_value,
    output logic            out_flag,
    output logic            out_last
);

    logic        dir_reg;
    logic [11:0] acc_reg;
    logic [11:0] acc_next;
    logic [3:0]  bits_reg;
    logic [3:0]  bits_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic [7:0]  byte_reg;
    logic        eom_reg;
    logic        oval_reg;
    logic [7:0]  oval_value_reg;
    logic        oflag_reg;
    logic        olast_reg;

    logic [7:0]  res_value;
    logic        res_flag;
    logic        res_last;
    logic [11:0] acc_step;
    logic [3:0]  bits_step;
    logic [2:0]  cnt_step;
    logic [11:0] shifted;
    logic [5:0]  idx;
    logic [11:0] acc_ins;
    logic [3:0]  bits_ins;

    assign idx = b32c_pkg::char_index(byte_reg);
    assign acc_ins = {acc_reg[6:0], idx[4:0]};
    assign bits_ins = bits_reg + 4'd5;

    always_comb
    begin
        stat.out_free  = !oval_reg || out_ready;
        stat.res_avail = 1'b0;
        stat.res_final = 1'b0;
        res_value      = 8'h00;
        res_flag       = 1'b1;
        res_last       = 1'b0;
        acc_step       = acc_reg;
        bits_step      = bits_reg;
        cnt_step       = cnt_reg + 3'd1;
        shifted        = 12'h000;
        if (!dir_reg)
        begin
            if (bits_reg >= 4'd5)
            begin
                bits_step = bits_reg - 4'd5;
                shifted = acc_reg >> bits_step;
                res_value = b32c_pkg::sym_char(shifted[4:0]);
                res_last = eom_reg && (bits_step == 4'd0) && (cnt_step == 3'd0);
                stat.res_avail = 1'b1;
            end
            else if (eom_reg && bits_reg != 4'd0)
            begin
                // Leftover bits are zero-filled at the low end of the symbol.
                shifted = acc_reg << (4'd5 - bits_reg);
                res_value = b32c_pkg::sym_char(shifted[4:0]);
                bits_step = 4'd0;
                res_last = (cnt_step == 3'd0);
                stat.res_avail = 1'b1;
            end
            else if (eom_reg && cnt_reg != 3'd0)
            begin
                res_value = b32c_pkg::PAD_CHAR;
                res_last = (cnt_step == 3'd0);
                stat.res_avail = 1'b1;
            end
            stat.res_final = res_last;
        end
        else
        begin
            cnt_step = cnt_reg;
            res_flag = 1'b0;
            if (!idx[5])
            begin
                acc_step = acc_ins;
                bits_step = bits_ins;
                if (bits_ins >= 4'd8)
                begin
                    bits_step = bits_ins - 4'd8;
                    shifted = acc_ins >> bits_step;
                    res_value = shifted[7:0];
                    res_flag = 1'b1;
                end
            end
            res_last = eom_reg;
            stat.res_avail = 1'b1;
            stat.res_final = 1'b1;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        if (cfg_we)
        begin
            acc_next  = 12'h000;
            bits_next = 4'd0;
            cnt_next  = 3'd0;
        end
        else if (cmd.accept && !dir_reg)
        begin
            acc_next  = {acc_reg[3:0], in_byte};
            bits_next = bits_reg + 4'd8;
        end
        else if (cmd.emit)
        begin
            if (res_last)
            begin
                acc_next  = 12'h000;
                bits_next = 4'd0;
                cnt_next  = 3'd0;
            end
            else
            begin
                acc_next  = acc_step;
                bits_next = bits_step;
                cnt_next  = cnt_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= 1'b0;
            acc_reg  <= 12'h000;
            bits_reg <= 4'd0;
            cnt_reg  <= 3'd0;
            eom_reg  <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dir_reg <= cfg_wdata;
            end
            acc_reg  <= acc_next;
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
            if (cmd.accept)
            begin
                eom_reg <= in_eom;
            end
            if (cmd.emit)
            begin
                oval_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= in_byte;
        end
        if (cmd.emit)
        begin
            oval_value_reg <= res_value;
            oflag_reg      <= res_flag;
            olast_reg      <= res_last;
        end
    end

    assign out_valid = oval_reg;
    assign out_value = oval_value_reg;
    assign out_flag  = oflag_reg;
    assign out_last  = olast_reg;

    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg <= 4'd12)
        else $error("bit count out of range");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && res_last && !cfg_we |=> bits_reg == 4'd0 && cnt_reg == 3'd0)
        else $error("message state not cleared after last word");

    a_decode_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        dir_reg |-> cnt_reg == 3'd0)
        else $error("symbol counter moved while decoding");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free && stat.res_avail)
        else $error("result loaded into a busy output register");

endmodule
